// File: design/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// shared types and constants of the bilinear resampler
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int unsigned POS_W  = 9;
    localparam int unsigned CFG_W  = 10;
    localparam int unsigned PIX_W  = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned WGT_W  = 2 * FRAC_W + 2;
    localparam int unsigned PROD_W = WGT_W + 8;
    localparam int unsigned SUM_W  = PROD_W + 2;

    localparam logic [FRAC_W:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [7:0]      CH_MAX  = 8'hFF;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_REQ  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_DST_W = 2'd2,
        REG_DST_H = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              func;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [PIX_W-1:0]  pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       index;
        logic [CFG_W-1:0] data;
    } t_cfg_beat;

    // four neighbors (upper-left, upper-right, lower-left, lower-right) and fractions
    typedef struct packed {
        logic [3:0][PIX_W-1:0] p;
        logic [FRAC_W-1:0]     fx;
        logic [FRAC_W-1:0]     fy;
    } t_px_beat;

endpackage

// File: design/bir_in_if.sv
// ----------------------------------------------------------------------------
// bir_in_if
// input item channel
// ----------------------------------------------------------------------------
interface bir_in_if import bir_pkg::*; ;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/bir_out_if.sv
// ----------------------------------------------------------------------------
// bir_out_if
// result pixel channel
// ----------------------------------------------------------------------------
interface bir_out_if import bir_pkg::*; ;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/bir_cfg_if.sv
// ----------------------------------------------------------------------------
// bir_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface bir_cfg_if import bir_pkg::*; ;
    logic      valid;
    logic      ready;
    t_cfg_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/bir_div.sv
// ----------------------------------------------------------------------------
// bir_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bir_div import bir_pkg::*; #(
    parameter int unsigned NW = 26,
    parameter int unsigned DW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic          q_bit;

    assign trial = {r_rem, r_num[NW-1]};
    assign q_bit = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_quot <= {r_quot[NW-2:0], q_bit};
            r_rem  <= q_bit ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

// File: design/bir_frame.sv
// ----------------------------------------------------------------------------
// bir_frame
// frame store with the access sequencer: at most one write per load, four reads per request
// ----------------------------------------------------------------------------
module bir_frame import bir_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_func             i_func,
    input  logic              i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x0,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x1,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_y0,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_y1,
    input  logic [FRAC_W-1:0] i_fx,
    input  logic [FRAC_W-1:0] i_fy,
    input  logic [PIX_W-1:0]  i_pixel,
    output logic              o_valid,
    output t_px_beat          o_beat,
    input  logic              i_ready
);
    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [PIX_W-1:0] r_mem [DEPTH];

    logic              r_m_v;
    t_func             r_m_func;
    logic              r_wr_en;
    logic [XW-1:0]     r_x0, r_x1;
    logic [YW-1:0]     r_y0, r_y1;
    logic [FRAC_W-1:0] r_fx, r_fy, r_hfx, r_hfy;
    logic [PIX_W-1:0]  r_pix;
    logic [1:0]        r_k, r_rdk;
    logic              r_rdv;
    logic [PIX_W-1:0]  r_rd;
    logic [PIX_W-1:0]  r_p00, r_p10, r_p01;
    logic              r_g_v;
    t_px_beat          r_g;

    logic          last_ok, rd_en, wr_en, m_done, m_free, cap_now;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [AW-1:0] addr;

    assign cap_now = r_rdv && (r_rdk == 2'd3);
    // last read only when the gather register is free the cycle after
    assign last_ok = (!r_g_v || i_ready) && !cap_now;
    assign rd_en   = r_m_v && (r_m_func == FUNC_REQ) && ((r_k != 2'd3) || last_ok);
    assign wr_en   = r_m_v && (r_m_func == FUNC_LOAD) && r_wr_en;
    assign m_done  = r_m_v && ((r_m_func == FUNC_LOAD) || ((r_k == 2'd3) && last_ok));
    assign m_free  = !r_m_v || m_done;
    assign o_ready = m_free;

    // bit 0 of the step picks the right column, bit 1 the lower row
    assign ax   = r_k[0] ? r_x1 : r_x0;
    assign ay   = r_k[1] ? r_y1 : r_y0;
    assign addr = AW'(32'(ay) * MAX_WIDTH + 32'(ax));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_k   <= '0;
            r_rdv <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            if (m_free) begin
                r_m_v <= i_valid;
                r_k   <= '0;
            end else if (rd_en) begin
                r_k <= r_k + 2'd1;
            end
            r_rdv <= rd_en;
            if (cap_now) begin
                r_g_v <= 1'b1;
            end else if (i_ready) begin
                r_g_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_free && i_valid) begin
            r_m_func <= i_func;
            r_wr_en  <= i_wr_en;
            r_x0     <= i_x0;
            r_x1     <= i_x1;
            r_y0     <= i_y0;
            r_y1     <= i_y1;
            r_fx     <= i_fx;
            r_fy     <= i_fy;
            r_pix    <= i_pixel;
        end
        r_rdk <= r_k;
        if (rd_en && (r_k == 2'd3)) begin
            r_hfx <= r_fx;
            r_hfy <= r_fy;
        end
        if (r_rdv) begin
            case (r_rdk)
                2'd0:    r_p00 <= r_rd;
                2'd1:    r_p10 <= r_rd;
                2'd2:    r_p01 <= r_rd;
                default: ;
            endcase
        end
        if (cap_now) begin
            r_g.p  <= {r_rd, r_p01, r_p10, r_p00};
            r_g.fx <= r_hfx;
            r_g.fy <= r_hfy;
        end
    end

    // single port: a cycle either writes or reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= r_pix;
        end else if (rd_en) begin
            r_rd <= r_mem[addr];
        end
    end

    assign o_valid = r_g_v;
    assign o_beat  = r_g;
endmodule

// File: design/bir_blend.sv
// ----------------------------------------------------------------------------
// bir_blend
// weight, product and sum stages of the per-channel blend
// ----------------------------------------------------------------------------
module bir_blend import bir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_px_beat         i_beat,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_pixel,
    input  logic             i_ready
);
    logic                  r_w_v, r_p_v, r_o_v;
    logic [3:0][PIX_W-1:0] r_w_p;
    logic [WGT_W-1:0]      r_w [4];
    logic [PROD_W-1:0]     r_prod [4][4];
    logic [PIX_W-1:0]      r_o;

    logic            o_free, p_free, w_free;
    logic [FRAC_W:0] gx, gy, hx, hy;
    logic [SUM_W-1:0] acc [4];
    logic [PIX_W-1:0] blended;

    assign o_free  = !r_o_v || i_ready;
    assign p_free  = !r_p_v || o_free;
    assign w_free  = !r_w_v || p_free;
    assign o_ready = w_free;

    assign hx = {1'b0, i_beat.fx};
    assign hy = {1'b0, i_beat.fy};
    assign gx = ONE_Q16 - hx;
    assign gy = ONE_Q16 - hy;

    always_comb begin
        blended = '0;
        for (int c = 0; c < 4; c++) begin
            acc[c] = SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1])
                   + SUM_W'(r_prod[c][2]) + SUM_W'(r_prod[c][3]);
            blended[8*c +: 8] = (acc[c][SUM_W-1:2*FRAC_W+8] != '0) ? CH_MAX
                              : acc[c][2*FRAC_W +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_free) r_w_v <= i_valid;
            if (p_free) r_p_v <= r_w_v;
            if (o_free) r_o_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && i_valid) begin
            r_w_p  <= i_beat.p;
            r_w[0] <= WGT_W'(gx) * WGT_W'(gy);
            r_w[1] <= WGT_W'(hx) * WGT_W'(gy);
            r_w[2] <= WGT_W'(gx) * WGT_W'(hy);
            r_w[3] <= WGT_W'(hx) * WGT_W'(hy);
        end
        if (p_free && r_w_v) begin
            for (int c = 0; c < 4; c++) begin
                for (int n = 0; n < 4; n++) begin
                    r_prod[c][n] <= PROD_W'(r_w_p[n][8*c +: 8]) * PROD_W'(r_w[n]);
                end
            end
        end
        if (o_free && r_p_v) begin
            r_o <= blended;
        end
    end

    assign o_valid = r_o_v;
    assign o_pixel = r_o;
endmodule

// File: design/bilinear_image_resize_top.sv
// ----------------------------------------------------------------------------
// bilinear_image_resize_top
// bilinear resampler over a stored rgba8 source frame
// ----------------------------------------------------------------------------
// usage
//   i_in beats carry func, pos_x, pos_y, pixel_in. a load beat (func 0) writes
//   one source pixel (if in range) and gives no result; a request beat (func 1) names a
//   destination pixel and gives one pixel_out beat on o_out, in request order.
//   i_cfg writes src_width, src_height, dst_width, dst_height by index 0..3.
// throughput
//   a load holds the frame memory port for one write, a request for four reads
//   (one per neighbor on the single-port store), so no beat enters the store
//   before a request's last read; loads run one per cycle while not stalled.
// request path
//   a request beat passes scale multiply, four reads, gather, weights,
//   products and channel sums before its result.
// reset and configuration
//   reset sets all sizes to 512 and computes both q10.16 scales with a
//   bit-serial divider, i_in not ready meanwhile. every register write
//   restarts the divider the same way. the frame store is not cleared;
//   only written pixels may be requested.
// stalls
//   a stalled o_out holds its beat; the stages behind it keep filling until
//   full, then i_in drops ready.
// ----------------------------------------------------------------------------
module bilinear_image_resize_top import bir_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bir_in_if.sink      i_in,
    bir_cfg_if.sink     i_cfg,
    bir_out_if.source   o_out
);
    localparam int unsigned XW  = $clog2(MAX_WIDTH);
    localparam int unsigned YW  = $clog2(MAX_HEIGHT);
    localparam int unsigned SXW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned SYW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned QXW = SXW + FRAC_W;
    localparam int unsigned QYW = SYW + FRAC_W;
    localparam int unsigned PXW = POS_W + QXW;
    localparam int unsigned PYW = POS_W + QYW;

    // size registers, raw as written
    logic [CFG_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic             r_div_go;

    // effective sizes: zero reads as one, source saturates to the store
    logic [SXW-1:0]   swe, lastx;
    logic [SYW-1:0]   she, lasty;
    logic [CFG_W-1:0] dwe, dhe;
    logic [QXW-1:0]   scale_x;
    logic [QYW-1:0]   scale_y;
    logic             busy_x, busy_y, div_busy;

    assign swe = (r_src_w == '0) ? SXW'(1)
               : ((32'(r_src_w) > MAX_WIDTH) ? SXW'(MAX_WIDTH) : SXW'(r_src_w));
    assign she = (r_src_h == '0) ? SYW'(1)
               : ((32'(r_src_h) > MAX_HEIGHT) ? SYW'(MAX_HEIGHT) : SYW'(r_src_h));
    assign dwe = (r_dst_w == '0) ? CFG_W'(1) : r_dst_w;
    assign dhe = (r_dst_h == '0) ? CFG_W'(1) : r_dst_h;
    assign lastx = swe - SXW'(1);
    assign lasty = she - SYW'(1);

    assign i_cfg.ready = 1'b1;
    assign div_busy    = r_div_go || busy_x || busy_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= CFG_W'(512);
            r_src_h  <= CFG_W'(512);
            r_dst_w  <= CFG_W'(512);
            r_dst_h  <= CFG_W'(512);
            r_div_go <= 1'b1;
        end else begin
            r_div_go <= i_cfg.valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_SRC_W: r_src_w <= i_cfg.data.data;
                    REG_SRC_H: r_src_h <= i_cfg.data.data;
                    REG_DST_W: r_dst_w <= i_cfg.data.data;
                    REG_DST_H: r_dst_h <= i_cfg.data.data;
                    default:   ;
                endcase
            end
        end
    end

    // scale = (src << 16) / dst per axis
    bir_div #(.NW(QXW), .DW(CFG_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ({swe, {FRAC_W{1'b0}}}),
        .i_den   (dwe),
        .o_busy  (busy_x),
        .o_quot  (scale_x)
    );

    bir_div #(.NW(QYW), .DW(CFG_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ({she, {FRAC_W{1'b0}}}),
        .i_den   (dhe),
        .o_busy  (busy_y),
        .o_quot  (scale_y)
    );

    // entry stage: takes the beat and forms the source positions
    logic              r_x_v;
    t_func             r_x_func;
    logic [POS_W-1:0]  r_x_px, r_x_py;
    logic [PIX_W-1:0]  r_x_pix;
    logic [PXW-1:0]    r_x_posx;
    logic [PYW-1:0]    r_x_posy;
    logic              m_ready, x_free, in_acc;

    assign x_free     = !r_x_v || m_ready;
    assign i_in.ready = x_free && !div_busy;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (x_free) begin
            r_x_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x_func <= t_func'(i_in.data.func);
            r_x_px   <= i_in.data.pos_x;
            r_x_py   <= i_in.data.pos_y;
            r_x_pix  <= i_in.data.pixel_in;
            r_x_posx <= PXW'(i_in.data.pos_x) * PXW'(scale_x);
            r_x_posy <= PYW'(i_in.data.pos_y) * PYW'(scale_y);
        end
    end

    // neighbor selection: past the last column or row the base saturates
    // and its fraction drops to zero; the second neighbor clamps to the edge
    logic [PXW-FRAC_W-1:0] basex;
    logic [PYW-FRAC_W-1:0] basey;
    logic [XW-1:0]         mx0, mx1, fx0;
    logic [YW-1:0]         my0, my1, fy0;
    logic [FRAC_W-1:0]     mfx, mfy;
    logic                  ovx, ovy, wr_ok;
    t_func                 f_sel;

    assign basex = r_x_posx[PXW-1:FRAC_W];
    assign basey = r_x_posy[PYW-1:FRAC_W];
    assign ovx   = basex > (PXW-FRAC_W)'(lastx);
    assign ovy   = basey > (PYW-FRAC_W)'(lasty);
    assign mx0   = ovx ? XW'(lastx) : XW'(basex);
    assign my0   = ovy ? YW'(lasty) : YW'(basey);
    assign mfx   = ovx ? '0 : r_x_posx[FRAC_W-1:0];
    assign mfy   = ovy ? '0 : r_x_posy[FRAC_W-1:0];
    assign mx1   = ((SXW + 1)'(mx0) + (SXW + 1)'(1) > (SXW + 1)'(lastx)) ? XW'(lastx)
                 : XW'(mx0 + XW'(1));
    assign my1   = ((SYW + 1)'(my0) + (SYW + 1)'(1) > (SYW + 1)'(lasty)) ? YW'(lasty)
                 : YW'(my0 + YW'(1));
    assign fx0   = XW'(r_x_px);
    assign fy0   = YW'(r_x_py);
    assign f_sel = r_x_func;
    assign wr_ok = (32'(r_x_px) < MAX_WIDTH) && (32'(r_x_py) < MAX_HEIGHT);

    logic     g_valid, g_ready;
    t_px_beat g_beat;

    bir_frame #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_x_v),
        .o_ready (m_ready),
        .i_func  (f_sel),
        .i_wr_en (wr_ok),
        .i_x0    ((f_sel == FUNC_LOAD) ? fx0 : mx0),
        .i_x1    (mx1),
        .i_y0    ((f_sel == FUNC_LOAD) ? fy0 : my0),
        .i_y1    (my1),
        .i_fx    (mfx),
        .i_fy    (mfy),
        .i_pixel (r_x_pix),
        .o_valid (g_valid),
        .o_beat  (g_beat),
        .i_ready (g_ready)
    );

    bir_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g_valid),
        .o_ready (g_ready),
        .i_beat  (g_beat),
        .o_valid (o_out.valid),
        .o_pixel (o_out.data.pixel_out),
        .i_ready (o_out.ready)
    );

    // no beat enters while a scale is being recomputed
    a_no_in_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !i_in.ready)
        else $error("input taken while scale divider busy");

    // a register write blocks input on the next cycle
    a_cfg_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> !i_in.ready)
        else $error("input ready right after register write");

    // an entry beat waiting on the frame sequencer stays put
    a_entry_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x_v && !m_ready) |=> (r_x_v && $stable(r_x_posx) && $stable(r_x_func)))
        else $error("entry stage lost a stalled beat");

endmodule
